>>> rtl/core/bls_pkg.sv
// Package for the Bresenham line stepper: payload structs, widths and
// configuration register indexes. Depends on nothing.
package bls_pkg;

    localparam int COORD_BITS = 16;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int WIN_BITS   = 15;
    localparam int COLOR_BITS = 24;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_HEIGHT = 1'd1;

    localparam logic [WIN_BITS-1:0] WINDOW_WIDTH_RESET  = 15'd1920;
    localparam logic [WIN_BITS-1:0] WINDOW_HEIGHT_RESET = 15'd1080;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [COORD_BITS-1:0] t_delta;
    typedef logic signed [ERR_BITS-1:0]   t_err;

    typedef struct packed {
        logic                  command;
        t_coord                x_start;
        t_coord                y_start;
        t_coord                x_end;
        t_coord                y_end;
        logic [COLOR_BITS-1:0] line_color;
    } t_in_item;

    typedef struct packed {
        t_coord                pixel_x;
        t_coord                pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_pixel;
    } t_out_item;

endpackage

>>> rtl/core/bresenham_line_stepper_unit.sv
// Top level of the Bresenham line stepper: line setup, one step per transfer
// and an output register. Depends on bls_pkg.
//
//   channel   direction  handshake                    payload
//   in        input      i_in_valid / o_in_ready      i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_ready    o_out_data (t_out_item)
//   cfg       input      i_cfg_we                     i_cfg_index, i_cfg_data
//
// A pixel appears in the output register in the cycle after the step
// transfer that emits it. The output register sets the rate: a new
// command is taken whenever it is empty or being drained in the same cycle.
// Synchronous active-low reset clears the line state and the window to its
// defaults. A stall on the output holds the register and stops input.
module bresenham_line_stepper_unit
    import bls_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_data,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [WIN_BITS-1:0]     i_cfg_data
);

    logic [WIN_BITS-1:0]   r_win_w, r_win_h;
    t_coord                r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    t_coord                n_cur_x, n_cur_y, n_tgt_x, n_tgt_y;
    t_delta                r_dx, r_dy, n_dx, n_dy;
    t_err                  r_err, n_err;
    logic                  r_neg_x, r_neg_y, n_neg_x, n_neg_y;
    t_delta                r_steps, r_limit, n_steps, n_limit;
    logic [COLOR_BITS-1:0] r_color, n_color;
    logic                  r_active, n_active;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  accept;
    logic                  emit;
    logic                  emit_last;
    logic                  walking;
    logic                  in_window;
    logic                  move_x, move_y;
    logic                  x_gt, y_gt;
    logic [COORD_BITS:0]   diff_x, diff_y;
    t_delta                abs_x, abs_y;
    logic [ERR_BITS:0]     err_sum;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        x_gt   = i_in_data.x_end > i_in_data.x_start;
        y_gt   = i_in_data.y_end > i_in_data.y_start;
        diff_x = {i_in_data.x_end[COORD_BITS-1], i_in_data.x_end}
               - {i_in_data.x_start[COORD_BITS-1], i_in_data.x_start};
        diff_y = {i_in_data.y_end[COORD_BITS-1], i_in_data.y_end}
               - {i_in_data.y_start[COORD_BITS-1], i_in_data.y_start};
        abs_x  = x_gt ? diff_x[COORD_BITS-1:0] : t_delta'(-diff_x);
        abs_y  = y_gt ? diff_y[COORD_BITS-1:0] : t_delta'(-diff_y);

        walking = ((r_cur_x != r_tgt_x) || (r_cur_y != r_tgt_y)) && (r_steps < r_limit);
        in_window = !r_cur_x[COORD_BITS-1] && (r_cur_x < $signed({1'b0, r_win_w}))
                 && !r_cur_y[COORD_BITS-1] && (r_cur_y < $signed({1'b0, r_win_h}));
        move_x  = r_err > -$signed({2'b00, r_dx});
        move_y  = r_err < $signed({2'b00, r_dy});
        err_sum = {r_err[ERR_BITS-1], r_err}
                - (move_x ? {3'b000, r_dy} : '0)
                + (move_y ? {3'b000, r_dx} : '0);

        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_tgt_x  = r_tgt_x;
        n_tgt_y  = r_tgt_y;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_err    = r_err;
        n_neg_x  = r_neg_x;
        n_neg_y  = r_neg_y;
        n_steps  = r_steps;
        n_limit  = r_limit;
        n_color  = r_color;
        n_active = r_active;
        emit      = 1'b0;
        emit_last = 1'b0;

        if (accept) begin
            if (i_in_data.command == CMD_LOAD) begin
                n_cur_x  = i_in_data.x_start;
                n_cur_y  = i_in_data.y_start;
                n_tgt_x  = i_in_data.x_end;
                n_tgt_y  = i_in_data.y_end;
                n_dx     = abs_x;
                n_dy     = abs_y;
                n_neg_x  = !x_gt;
                n_neg_y  = !y_gt;
                n_err    = (abs_x >= abs_y) ? t_err'({2'b00, abs_x >> 1})
                                            : -t_err'({2'b00, abs_y >> 1});
                n_limit  = (abs_x > abs_y) ? abs_x : abs_y;
                n_steps  = '0;
                n_color  = i_in_data.line_color;
                n_active = 1'b1;
            end else if (r_active) begin
                if (walking) begin
                    emit  = in_window;
                    n_err = err_sum[ERR_BITS-1:0];
                    if (move_x) begin
                        n_cur_x = r_neg_x ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
                    end
                    if (move_y) begin
                        n_cur_y = r_neg_y ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
                    end
                    n_steps = r_steps + 1'b1;
                end else begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    n_active  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_w     <= WINDOW_WIDTH_RESET;
            r_win_h     <= WINDOW_HEIGHT_RESET;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_tgt_x     <= '0;
            r_tgt_y     <= '0;
            r_dx        <= '0;
            r_dy        <= '0;
            r_err       <= '0;
            r_neg_x     <= 1'b0;
            r_neg_y     <= 1'b0;
            r_steps     <= '0;
            r_limit     <= '0;
            r_color     <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WINDOW_WIDTH:  r_win_w <= i_cfg_data;
                    REG_WINDOW_HEIGHT: r_win_h <= i_cfg_data;
                    default: ;
                endcase
            end
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_tgt_x  <= n_tgt_x;
            r_tgt_y  <= n_tgt_y;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_err    <= n_err;
            r_neg_x  <= n_neg_x;
            r_neg_y  <= n_neg_y;
            r_steps  <= n_steps;
            r_limit  <= n_limit;
            r_color  <= n_color;
            r_active <= n_active;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.pixel_x     <= r_cur_x;
            r_out.pixel_y     <= r_cur_y;
            r_out.pixel_color <= r_color;
            r_out.last_pixel  <= emit_last;
        end
    end

endmodule

>>> rtl/core/bls_checker.sv
// Port-level checker for the Bresenham line stepper and its bind statement.
// Depends on bls_pkg and bresenham_line_stepper_unit.
module bls_checker
    import bls_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input t_in_item                i_in_data,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input t_out_item               o_out_data
);

    // A pending result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output result changed or dropped while stalled");

    // The input is never blocked while the output register is empty.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

    // A load transfer produces no result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_data.command == CMD_LOAD)) |=> !o_out_valid)
        else $error("load transfer produced a result");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind bresenham_line_stepper_unit bls_checker u_bls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
